// ===== design/sws_pkg.sv =====
// Shared constants for the sliding window latency statistics block.
// Holds parameter defaults, register indexes and command codes.
// No dependencies.
package sws_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned NUM_TYPES_DEF  = 64;
  localparam int unsigned NUM_POINTS_DEF = 4;

  // Percentile point registers that exist on the port.
  localparam int unsigned REG_POINTS = 4;

  localparam int unsigned DUR_W   = 32;
  localparam int unsigned WLEN_W  = 7;
  localparam int unsigned PCNT_W  = 3;
  localparam int unsigned POINT_W = 17;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [POINT_W-1:0] POINT_ONE = 17'h10000;
  localparam logic [WLEN_W-1:0]  WLEN_RST  = 7'd64;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [2:0] REG_POINT_COUNT   = 3'd1;
  localparam logic [2:0] REG_POINT_ZERO    = 3'd2;
  localparam logic [2:0] REG_POINT_ONE     = 3'd3;
  localparam logic [2:0] REG_POINT_TWO     = 3'd4;
  localparam logic [2:0] REG_POINT_THREE   = 3'd5;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

endpackage

// ===== design/sws_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sws_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// No dependencies.
module sws_div #(
  parameter int unsigned NW = 38,
  parameter int unsigned DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW:0]      rem_r, rem_nxt;
  logic [DW-1:0]    dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DW:0]      trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DW-1:0], quo_r[NW-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = trial - {1'b0, dsr_r};
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== design/sliding_window_latency_stats.sv =====
// Top level of the sliding window latency statistics block.
// Depends on sws_pkg, sws_ram (sample ring and series records), sws_div (mean).
//
//  channel   direction  handshake            payload
//  in_*      input      in_valid / in_stall  action, type_id, domain, duration_ns
//  out_*     output     out_valid/out_stall  count, empty, min, max, mean, point
//  cfg (APB) input      psel/penable/pwrite  window length, point count, points
//
// One transaction at a time. An append steps through series record read,
// oldest sample read, write back of sample and record.
// A query of n samples runs a rank scan over the single sample RAM read port;
// the mean divider works through the running sum bit by bit beside the scan,
// and the results follow once the longer of the two is done. An empty series
// skips both and answers straight after the series record read.
// Reset and any window_length write clear all series at once through per-series
// valid bits; no clearing pass. Results are held in the output register while
// out_stall is high; the block takes no new transaction until the last result
// of the current one is in that register.
module sliding_window_latency_stats #(
  parameter int unsigned MAX_WINDOW = sws_pkg::MAX_WINDOW_DEF,
  parameter int unsigned NUM_TYPES  = sws_pkg::NUM_TYPES_DEF,
  parameter int unsigned NUM_POINTS = sws_pkg::NUM_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [5:0]                  in_type_id,
  input  logic                        in_domain,
  input  logic [31:0]                 in_duration_ns,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [6:0]                  out_sample_count,
  output logic                        out_is_empty,
  output logic [31:0]                 out_minimum_ns,
  output logic [31:0]                 out_maximum_ns,
  output logic [31:0]                 out_mean_ns,
  output logic [1:0]                  out_point_index,
  output logic                        out_has_point,
  output logic [31:0]                 out_point_value_ns,
  output logic                        out_last,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sws_pkg::ADDR_W-1:0]  paddr,
  input  logic [sws_pkg::DATA_W-1:0]  pwdata,
  output logic [sws_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned SERIES  = 2 * NUM_TYPES;
  localparam int unsigned SBW     = $clog2(SERIES);
  localparam int unsigned CW      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SW      = sws_pkg::DUR_W + CW;
  localparam int unsigned MW      = PW + CW + SW;
  localparam int unsigned SDEPTH  = SERIES * MAX_WINDOW;
  localparam int unsigned AW      = $clog2(SDEPTH);
  localparam int unsigned PRW     = sws_pkg::POINT_W + CW;
  localparam int unsigned NP      = sws_pkg::REG_POINTS;
  localparam int unsigned KW      = $clog2(NP);
  localparam int unsigned NRW     = $clog2(NP + 1);
  localparam int unsigned DW      = sws_pkg::DUR_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_META = 4'd1;
  localparam logic [3:0] ST_OLD  = 4'd2;
  localparam logic [3:0] ST_RANK = 4'd3;
  localparam logic [3:0] ST_VI   = 4'd4;
  localparam logic [3:0] ST_VI2  = 4'd5;
  localparam logic [3:0] ST_SCAN = 4'd6;
  localparam logic [3:0] ST_EVAL = 4'd7;
  localparam logic [3:0] ST_WAIT = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  // ---------------------------------------------------------------- config
  logic [sws_pkg::WLEN_W-1:0]  wlen_r;
  logic [sws_pkg::PCNT_W-1:0]  pcnt_r;
  logic [sws_pkg::POINT_W-1:0] point_r [NP];
  logic                        cfg_wr;
  logic [2:0]                  cfg_idx;
  logic [CW-1:0]               w_eff;
  logic [NRW-1:0]              pc_eff;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= sws_pkg::WLEN_RST;
      pcnt_r <= '0;
      for (int p = 0; p < NP; p++) begin
        point_r[p] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sws_pkg::REG_WINDOW_LENGTH: wlen_r     <= pwdata[sws_pkg::WLEN_W-1:0];
        sws_pkg::REG_POINT_COUNT:   pcnt_r     <= pwdata[sws_pkg::PCNT_W-1:0];
        sws_pkg::REG_POINT_ZERO:    point_r[0] <= pwdata[sws_pkg::POINT_W-1:0];
        sws_pkg::REG_POINT_ONE:     point_r[1] <= pwdata[sws_pkg::POINT_W-1:0];
        sws_pkg::REG_POINT_TWO:     point_r[2] <= pwdata[sws_pkg::POINT_W-1:0];
        sws_pkg::REG_POINT_THREE:   point_r[3] <= pwdata[sws_pkg::POINT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sws_pkg::REG_WINDOW_LENGTH: prdata = 32'(wlen_r);
      sws_pkg::REG_POINT_COUNT:   prdata = 32'(pcnt_r);
      sws_pkg::REG_POINT_ZERO:    prdata = 32'(point_r[0]);
      sws_pkg::REG_POINT_ONE:     prdata = 32'(point_r[1]);
      sws_pkg::REG_POINT_TWO:     prdata = 32'(point_r[2]);
      sws_pkg::REG_POINT_THREE:   prdata = 32'(point_r[3]);
      default:                    prdata = '0;
    endcase
  end

  // Clamp window length into 1..MAX_WINDOW.
  always_comb begin
    if (wlen_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(wlen_r);
    end
  end

  // Points in use: limited by the parameter and by the register file.
  always_comb begin
    pc_eff = NRW'(pcnt_r);
    if (32'(pcnt_r) > 32'(NUM_POINTS)) begin
      pc_eff = NRW'(NUM_POINTS);
    end
    if (32'(pcnt_r) > 32'(NP) && 32'(NUM_POINTS) > 32'(NP)) begin
      pc_eff = NRW'(NP);
    end
  end

  // ---------------------------------------------------------------- state
  logic [3:0]     state_r;
  logic           act_r;
  logic           typ_ok_r;
  logic [SBW-1:0] ser_r;
  logic [AW-1:0]  base_r;
  logic [DW-1:0]  dur_r;

  logic           in_acc;
  logic           typ_ok_in;
  logic [SBW-1:0] ser_in;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign typ_ok_in = 32'(in_type_id) < 32'(NUM_TYPES);
  assign ser_in    = typ_ok_in ? SBW'(32'(in_domain) * NUM_TYPES + 32'(in_type_id)) : '0;

  // Series valid bits: an unset bit reads as an empty, zeroed record.
  logic [SERIES-1:0] svld_r;

  // series record RAM: {position, count, sum}
  logic          meta_we;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic [SBW-1:0] meta_raddr;

  // sample ring RAM
  logic          smp_we;
  logic [AW-1:0] smp_waddr, smp_raddr;
  logic [DW-1:0] smp_wdata, smp_rdata;

  sws_ram #(.WIDTH(MW), .DEPTH(SERIES)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (ser_r),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  sws_ram #(.WIDTH(DW), .DEPTH(SDEPTH)) u_smp (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (smp_wdata),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  assign meta_raddr = (state_r == ST_IDLE) ? ser_in : ser_r;

  // decoded record
  logic [PW-1:0] m_pos, m_posx;
  logic [CW-1:0] m_cnt;
  logic [SW-1:0] m_sum;
  logic          m_vld;

  assign m_vld = svld_r[ser_r];
  assign m_pos = m_vld ? meta_rdata[MW-1 -: PW] : '0;
  assign m_cnt = m_vld ? meta_rdata[SW +: CW]   : '0;
  assign m_sum = m_vld ? meta_rdata[SW-1:0]     : '0;
  assign m_posx = (32'(m_pos) >= 32'(w_eff)) ? '0 : m_pos;

  // append working registers
  logic [PW-1:0] pos_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] sum_r;

  // query working registers
  logic [CW-1:0]  n_r, i_r, j_r, less_r, eq_r;
  logic [DW-1:0]  vi_r, min_r, max_r, mean_r;
  logic [CW-1:0]  idx_r [NP];
  logic [DW-1:0]  pv_r  [NP];
  logic           empty_r;
  logic [NRW-1:0] nres_r;
  logic           haspt_r;
  logic [KW-1:0]  k_r;

  // divider
  logic          div_start, div_busy;
  logic [SW-1:0] div_q;

  sws_div #(.NW(SW), .DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (m_sum),
    .divisor  (m_cnt),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // output register
  logic          ov_r;
  logic [6:0]    o_cnt_r;
  logic          o_empty_r, o_has_r, o_last_r;
  logic [DW-1:0] o_min_r, o_max_r, o_mean_r, o_pv_r;
  logic [1:0]    o_pidx_r;
  logic          o_load;
  logic          k_last;

  assign k_last = (NRW'(k_r) + NRW'(1)) == nres_r;
  assign o_load = (state_r == ST_OUT) && (!ov_r || !out_stall);

  // append write back
  logic          a_full;
  logic [SW-1:0] a_sum;
  logic [PW:0]   a_pinc;

  assign a_full = cnt_r >= w_eff;
  assign a_sum  = sum_r - (a_full ? SW'(smp_rdata) : '0) + SW'(dur_r);
  assign a_pinc = {1'b0, pos_r} + 1'b1;

  assign smp_we    = (state_r == ST_OLD);
  assign smp_waddr = base_r + AW'(pos_r);
  assign smp_wdata = dur_r;
  assign meta_we   = (state_r == ST_OLD);
  assign meta_wdata = {(32'(a_pinc) >= 32'(w_eff)) ? PW'(0) : a_pinc[PW-1:0],
                       a_full ? cnt_r : cnt_r + 1'b1,
                       a_sum};

  // sample read address: oldest slot for appends, rank scan for queries
  always_comb begin
    unique case (state_r)
      ST_META: smp_raddr = base_r + AW'(m_posx);
      ST_VI:   smp_raddr = base_r + AW'(i_r);
      default: smp_raddr = base_r + AW'(j_r);
    endcase
  end

  assign div_start = (state_r == ST_META) && (act_r == sws_pkg::ACT_QUERY) &&
                     typ_ok_r && (m_cnt != '0);

  // rank for each point: ceil(p*n) - (p>0), clamped to n-1
  logic [sws_pkg::POINT_W-1:0] p_cl  [NP];
  logic [PRW:0]                p_rk  [NP];
  logic [CW-1:0]               p_idx [NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      p_cl[p] = (point_r[p] > sws_pkg::POINT_ONE) ? sws_pkg::POINT_ONE : point_r[p];
      p_rk[p] = ((PRW+1)'(p_cl[p]) * (PRW+1)'(n_r) + (PRW+1)'(16'hFFFF)) >> 16;
      if (p_cl[p] != '0) begin
        p_rk[p] = p_rk[p] - 1'b1;
      end
      if (p_rk[p] > (PRW+1)'(n_r - 1'b1)) begin
        p_idx[p] = n_r - 1'b1;
      end else begin
        p_idx[p] = CW'(p_rk[p]);
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      svld_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        ov_r <= 1'b0;
      end
      if (o_load) begin
        ov_r <= 1'b1;
      end
      if (state_r == ST_OLD) begin
        svld_r[ser_r] <= 1'b1;
      end
      // window length write drops every series
      if (cfg_wr && cfg_idx == sws_pkg::REG_WINDOW_LENGTH) begin
        svld_r <= '0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_META;
          end
        end
        ST_META: begin
          if (act_r == sws_pkg::ACT_APPEND) begin
            state_r <= typ_ok_r ? ST_OLD : ST_IDLE;
          end else if (!typ_ok_r || m_cnt == '0) begin
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_RANK;
          end
        end
        ST_OLD:  state_r <= ST_IDLE;
        ST_RANK: state_r <= ST_VI;
        ST_VI:   state_r <= ST_VI2;
        ST_VI2:  state_r <= ST_SCAN;
        ST_SCAN: begin
          if (j_r >= n_r) begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_r <= (i_r + 1'b1 >= n_r) ? ST_WAIT : ST_VI;
        end
        ST_WAIT: begin
          if (!div_busy) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (o_load && k_last) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_r    <= in_action;
          typ_ok_r <= typ_ok_in;
          ser_r    <= ser_in;
          base_r   <= AW'(32'(ser_in) * MAX_WINDOW);
          dur_r    <= in_duration_ns;
        end
      end
      ST_META: begin
        pos_r   <= m_posx;
        cnt_r   <= m_cnt;
        sum_r   <= m_sum;
        n_r     <= typ_ok_r ? m_cnt : '0;
        empty_r <= !typ_ok_r || m_cnt == '0;
        i_r     <= '0;
        k_r     <= '0;
        min_r   <= '1;
        max_r   <= '0;
        haspt_r <= pc_eff != '0;
        nres_r  <= (!typ_ok_r || m_cnt == '0 || pc_eff == '0) ? NRW'(1) : pc_eff;
      end
      ST_RANK: begin
        for (int p = 0; p < NP; p++) begin
          idx_r[p] <= p_idx[p];
        end
      end
      ST_VI: begin
        j_r <= '0;
      end
      ST_VI2: begin
        // candidate arrives; start scanning from slot zero
        vi_r   <= smp_rdata;
        less_r <= '0;
        eq_r   <= '0;
        j_r    <= CW'(1);
      end
      ST_SCAN: begin
        if (smp_rdata < vi_r) begin
          less_r <= less_r + 1'b1;
        end
        if (smp_rdata == vi_r) begin
          eq_r <= eq_r + 1'b1;
        end
        if (smp_rdata < min_r) begin
          min_r <= smp_rdata;
        end
        if (smp_rdata > max_r) begin
          max_r <= smp_rdata;
        end
        if (j_r < n_r) begin
          j_r <= j_r + 1'b1;
        end
      end
      ST_EVAL: begin
        // candidate covers ranks less .. less+eq-1
        for (int p = 0; p < NP; p++) begin
          if (less_r <= idx_r[p] && idx_r[p] < less_r + eq_r) begin
            pv_r[p] <= vi_r;
          end
        end
        i_r <= i_r + 1'b1;
      end
      ST_WAIT: begin
        if (div_q > SW'({DW{1'b1}})) begin
          mean_r <= '1;
        end else begin
          mean_r <= div_q[DW-1:0];
        end
      end
      ST_OUT: begin
        if (o_load) begin
          k_r <= k_r + 1'b1;
        end
      end
      default: ;
    endcase

    if (o_load) begin
      o_empty_r <= empty_r;
      o_last_r  <= k_last;
      if (empty_r) begin
        o_cnt_r  <= '0;
        o_min_r  <= '0;
        o_max_r  <= '0;
        o_mean_r <= '0;
        o_pidx_r <= '0;
        o_has_r  <= 1'b0;
        o_pv_r   <= '0;
      end else begin
        o_cnt_r  <= 7'(n_r);
        o_min_r  <= min_r;
        o_max_r  <= max_r;
        o_mean_r <= mean_r;
        o_pidx_r <= haspt_r ? 2'(k_r) : 2'b00;
        o_has_r  <= haspt_r;
        o_pv_r   <= haspt_r ? pv_r[k_r] : '0;
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_sample_count   = o_cnt_r;
  assign out_is_empty       = o_empty_r;
  assign out_minimum_ns     = o_min_r;
  assign out_maximum_ns     = o_max_r;
  assign out_mean_ns        = o_mean_r;
  assign out_point_index    = o_pidx_r;
  assign out_has_point      = o_has_r;
  assign out_point_value_ns = o_pv_r;
  assign out_last           = o_last_r;

endmodule

// ===== design/sws_checker.sv =====
// Port-level checks for sliding_window_latency_stats, bound to the top level.
// Depends on nothing but the top level's ports.
module sws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_is_empty,
  input logic        out_has_point,
  input logic [1:0]  out_point_index,
  input logic [31:0] out_minimum_ns,
  input logic [31:0] out_maximum_ns,
  input logic [31:0] out_mean_ns,
  input logic        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_last)
    else $error("empty series answer is not final");

  a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_point |-> out_point_index == 2'd0)
    else $error("point index set without a point");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |-> out_minimum_ns <= out_maximum_ns)
    else $error("minimum above maximum");

  a_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |->
      out_mean_ns >= out_minimum_ns && out_mean_ns <= out_maximum_ns)
    else $error("mean outside window range");

endmodule

bind sliding_window_latency_stats sws_checker u_sws_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_is_empty    (out_is_empty),
  .out_has_point   (out_has_point),
  .out_point_index (out_point_index),
  .out_minimum_ns  (out_minimum_ns),
  .out_maximum_ns  (out_maximum_ns),
  .out_mean_ns     (out_mean_ns),
  .out_last        (out_last)
);
